// ===== rtl/core/adsr_pkg.sv =====
// adsr_pkg: shared constants and types for the polyphonic adsr envelope unit
// no dependencies
`default_nettype none
package adsr_pkg;
  localparam int VOICES_DEF = 16;
  localparam int COUNT_BITS_DEF = 20;
  localparam int LEN_W = 20;
  localparam int LVL_W = 16;
  localparam int VOICE_W = 4;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ON   = 2'd1,
    OP_OFF  = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_RELEASE = 2'd2,
    REG_SUSTAIN = 2'd3
  } reg_idx_t;
endpackage
`default_nettype wire

// ===== rtl/core/adsr_serdiv.sv =====
// adsr_serdiv: restoring bit-serial divider, one quotient bit per cycle
// depends on adsr_pkg
`default_nettype none
module adsr_serdiv #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 20
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);
  import adsr_pkg::*;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] dsor;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;

  assign trial = {rem[DEN_W-1:0], quo[NUM_W-1]};
  assign diff = {1'b0, trial} - {2'b00, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(NUM_W);
        quo <= num;
        rem <= '0;
        dsor <= den;
      end else if (run) begin
        if (!diff[DEN_W+1]) begin
          rem <= diff[DEN_W:0];
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/polyphonic_adsr_envelope_unit.sv =====
// polyphonic_adsr_envelope_unit: top level, voice state, sequencer, config
// depends on adsr_pkg and adsr_serdiv
`default_nettype none
// Usage: pulse start with opcode and voice while busy is low. Note on and
// note off emit nothing. A tick walks the voices in ascending order; for
// each active voice a registered multiply feeds a restoring serial divider
// that makes one quotient bit a cycle. Each result shows on voice_out,
// level and last for exactly one cycle with strobe high; last marks the
// final voice of the tick. The receiver cannot stall. Config writes
// (cfg_we, cfg_index, cfg_data) take effect at once; the user must make
// them only while busy is low, the block itself does not enforce this.
// Synchronous rst restores register defaults and idles all voices; voice
// state lives in flip-flops with per-voice fields, no clearing pass.
// Unused opcodes and out-of-range voices are accepted and ignored.
module polyphonic_adsr_envelope_unit #(
  parameter int VOICES = adsr_pkg::VOICES_DEF,
  parameter int COUNT_BITS = adsr_pkg::COUNT_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   opcode,
  input  wire logic [adsr_pkg::VOICE_W-1:0] voice,
  output logic                              strobe,
  output logic [adsr_pkg::VOICE_W-1:0]      voice_out,
  output logic [adsr_pkg::LVL_W-1:0]        level,
  output logic                              last,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [adsr_pkg::LEN_W-1:0]   cfg_data
);
  import adsr_pkg::*;
  localparam int VI_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VC_W = $clog2(VOICES + 1);
  localparam int NUM_W = LEN_W + LVL_W + 1;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_MUL, S_DIV, S_EMIT} st_t;

  st_t st;
  logic [LEN_W-1:0] a_len, d_len, r_len;
  logic [LVL_W-1:0] sus;
  phase_t           ph [VOICES];
  logic [COUNT_BITS-1:0] cnt [VOICES];
  logic [LVL_W-1:0] rel_start [VOICES];
  logic [LVL_W-1:0] last_lvl [VOICES];
  logic [VI_W-1:0]  vi;
  logic [VC_W-1:0]  pos;
  logic [LEN_W-1:0] n_sel, c_cap;
  logic [LEN_W-1:0] mul_a;
  logic [LVL_W:0]   mul_b;
  logic [NUM_W-1:0] prod;
  logic             div_go, div_done;
  logic [NUM_W-1:0] div_q;
  logic             any_after;
  logic [LVL_W:0]   env;
  logic [LVL_W-1:0] env_sat;
  logic             pend;
  logic [VOICE_W-1:0] pend_v;
  logic [LVL_W-1:0] pend_l;
  logic [COUNT_BITS-1:0] c_cur;
  logic             c_ge;

  function automatic logic [LEN_W-1:0] len1(input logic [LEN_W-1:0] x);
    return (x == '0) ? LEN_W'(1) : x;
  endfunction

  assign c_cur = cnt[vi];
  // count compared at the wider of the two widths
  localparam int CW = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
  assign c_ge = CW'(c_cur) >= CW'(n_sel);
  assign c_cap = c_ge ? n_sel : LEN_W'(c_cur);

  always_comb begin
    unique case (ph[vi])
      PH_ATTACK: begin
        n_sel = len1(a_len);
        mul_b = (LVL_W + 1)'(1) << LVL_W;
      end
      PH_DECAY: begin
        n_sel = len1(d_len);
        mul_b = ((LVL_W + 1)'(1) << LVL_W) - {1'b0, sus};
      end
      PH_RELEASE: begin
        n_sel = len1(r_len);
        mul_b = {1'b0, rel_start[vi]};
      end
      default: begin
        n_sel = LEN_W'(1);
        mul_b = '0;
      end
    endcase
  end

  // release scales by the samples still to go
  assign mul_a = (ph[vi] == PH_RELEASE) ? n_sel - c_cap : c_cap;

  adsr_serdiv #(.NUM_W(NUM_W), .DEN_W(LEN_W)) u_div (
    .clk(clk), .rst(rst), .start(div_go), .num(prod), .den(n_sel),
    .done(div_done), .quo(div_q)
  );

  always_comb begin
    unique case (ph[vi])
      PH_ATTACK:  env = div_q[LVL_W:0];
      PH_DECAY:   env = ((LVL_W + 1)'(1) << LVL_W) - div_q[LVL_W:0];
      PH_SUSTAIN: env = {1'b0, sus};
      PH_RELEASE: env = c_ge ? '0 : div_q[LVL_W:0];
      default:    env = '0;
    endcase
    env_sat = env[LVL_W] ? '1 : env[LVL_W-1:0];
  end

  assign busy = (st != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      a_len <= LEN_W'(441);
      d_len <= LEN_W'(4410);
      r_len <= LEN_W'(8820);
      sus <= LVL_W'(45875);
      strobe <= 1'b0;
      last <= 1'b0;
      pend <= 1'b0;
      div_go <= 1'b0;
      vi <= '0;
      for (int i = 0; i < VOICES; i++) begin
        ph[i] <= PH_IDLE;
        cnt[i] <= '0;
        rel_start[i] <= '0;
        last_lvl[i] <= '0;
      end
    end else begin
      strobe <= 1'b0;
      last <= 1'b0;
      div_go <= 1'b0;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_ATTACK:  a_len <= cfg_data;
          REG_DECAY:   d_len <= cfg_data;
          REG_RELEASE: r_len <= cfg_data;
          REG_SUSTAIN: sus <= cfg_data[LVL_W-1:0];
        endcase
      end
      unique case (st)
        S_IDLE: begin
          if (start) begin
            priority if (opcode == OP_TICK) begin
              st <= S_SCAN;
              vi <= '0;
              pos <= '0;
              pend <= 1'b0;
            end else if (opcode == OP_ON && 32'(voice) < VOICES) begin
              ph[VI_W'(voice)] <= PH_ATTACK;
              cnt[VI_W'(voice)] <= '0;
              last_lvl[VI_W'(voice)] <= '0;
              st <= S_EMIT;
            end else if (opcode == OP_OFF && 32'(voice) < VOICES) begin
              if (ph[VI_W'(voice)] != PH_IDLE) begin
                ph[VI_W'(voice)] <= PH_RELEASE;
                cnt[VI_W'(voice)] <= '0;
                rel_start[VI_W'(voice)] <= last_lvl[VI_W'(voice)];
              end
              st <= S_EMIT;
            end else begin
              st <= S_EMIT;
            end
          end
        end
        S_SCAN: begin
          if (pos == VC_W'(VOICES)) begin
            if (pend) begin
              strobe <= 1'b1;
              last <= 1'b1;
              voice_out <= pend_v;
              level <= pend_l;
            end
            pend <= 1'b0;
            st <= S_EMIT;
          end else if (ph[vi] == PH_IDLE) begin
            pos <= pos + 1'b1;
            vi <= vi + 1'b1;
          end else begin
            prod <= NUM_W'(mul_a) * NUM_W'(mul_b);
            st <= S_MUL;
          end
        end
        S_MUL: begin
          div_go <= 1'b1;
          st <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (pend) begin
              strobe <= 1'b1;
              voice_out <= pend_v;
              level <= pend_l;
            end
            pend <= 1'b1;
            pend_v <= VOICE_W'(vi);
            pend_l <= env_sat;
            last_lvl[vi] <= env_sat;
            if (c_ge && ph[vi] != PH_SUSTAIN) begin
              unique case (ph[vi])
                PH_ATTACK:  ph[vi] <= PH_DECAY;
                PH_DECAY:   ph[vi] <= PH_SUSTAIN;
                default:    ph[vi] <= PH_IDLE;
              endcase
              cnt[vi] <= COUNT_BITS'(1);
            end else if (c_cur != CMAX) begin
              cnt[vi] <= c_cur + 1'b1;
            end
            pos <= pos + 1'b1;
            vi <= vi + 1'b1;
            st <= S_SCAN;
          end
        end
        S_EMIT: st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== test/adsr_env_checker.sv =====
// adsr_env_checker: watches the item, result and config ports of the envelope unit,
// predicts every level and compares results in order; depends on adsr_pkg
module adsr_env_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [1:0]                   opcode,
  input  logic [adsr_pkg::VOICE_W-1:0] voice,
  input  logic                         strobe,
  input  logic [adsr_pkg::VOICE_W-1:0] voice_out,
  input  logic [adsr_pkg::LVL_W-1:0]   level,
  input  logic                         last,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [adsr_pkg::LEN_W-1:0]   cfg_data,
  output int                           errors,
  output int                           pending
);
  import adsr_pkg::*;
  localparam int NV = VOICES_DEF;
  localparam logic [63:0] FULL = 64'd65536;
  localparam logic [63:0] CMAX = (64'd1 << COUNT_BITS_DEF) - 1;

  typedef struct packed {
    logic [VOICE_W-1:0] vc;
    logic [LVL_W-1:0]   lvl;
    logic               lst;
  } env_level_t;

  // newest at the front, oldest at the back
  env_level_t levels_q[$];
  phase_t     ph[NV];
  logic [63:0] cnt[NV];
  logic [15:0] rel_from[NV];
  logic [15:0] prev_lvl[NV];
  logic [LEN_W-1:0] att_len, dec_len, rel_len;
  logic [15:0] sus_lvl;

  assign pending = levels_q.size();

  function automatic logic [63:0] nz(logic [LEN_W-1:0] x);
    return (x == 0) ? 64'd1 : 64'(x);
  endfunction

  function automatic logic [63:0] capped(logic [63:0] c, logic [63:0] n);
    return (c < n) ? c : n;
  endfunction

  task automatic predict_tick();
    logic [63:0] c, n, env;
    int k;
    k = -1;
    for (int v = 0; v < NV; v++) begin
      if (ph[v] == PH_IDLE) continue;
      c = cnt[v];
      env = 0;
      case (ph[v])
        PH_ATTACK: begin
          n = nz(att_len);
          env = (capped(c, n) * FULL) / n;
          if (c >= n) begin ph[v] = PH_DECAY; c = 0; end
        end
        PH_DECAY: begin
          n = nz(dec_len);
          env = FULL - (capped(c, n) * (FULL - 64'(sus_lvl))) / n;
          if (c >= n) begin ph[v] = PH_SUSTAIN; c = 0; end
        end
        PH_SUSTAIN: env = 64'(sus_lvl);
        default: begin
          n = nz(rel_len);
          env = (64'(rel_from[v]) * (n - capped(c, n))) / n;
          if (c >= n) begin ph[v] = PH_IDLE; env = 0; end
        end
      endcase
      if (c < CMAX) c++;
      cnt[v] = c;
      if (env > 64'd65535) env = 64'd65535;
      prev_lvl[v] = env[15:0];
      levels_q.push_front('{vc: v[VOICE_W-1:0], lvl: env[15:0], lst: 1'b0});
      k = 0;
    end
    if (k >= 0) levels_q[k].lst = 1'b1;
  endtask

  always @(posedge clk) begin
    env_level_t e;
    if (rst) begin
      errors <= 0;
      levels_q.delete();
      att_len = 441; dec_len = 4410; rel_len = 8820; sus_lvl = 45875;
      for (int v = 0; v < NV; v++) begin
        ph[v] = PH_IDLE; cnt[v] = 0; rel_from[v] = 0; prev_lvl[v] = 0;
      end
    end else begin
      if (strobe) begin
        if (levels_q.size() == 0) begin
          $display("%0t: unexpected level voice %0d level %0d last %0b",
                   $time, voice_out, level, last);
          errors <= errors + 1;
        end else begin
          e = levels_q.pop_back();
          if (e.vc !== voice_out || e.lvl !== level || e.lst !== last) begin
            $display("%0t: mismatch expected voice %0d level %0d last %0b, got %0d %0d %0b",
                     $time, e.vc, e.lvl, e.lst, voice_out, level, last);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_ATTACK:  att_len = cfg_data;
          REG_DECAY:   dec_len = cfg_data;
          REG_RELEASE: rel_len = cfg_data;
          REG_SUSTAIN: sus_lvl = cfg_data[15:0];
        endcase
      end
      if (start && !busy) begin
        case (opcode_t'(opcode))
          OP_TICK: predict_tick();
          OP_ON: begin
            ph[voice] = PH_ATTACK; cnt[voice] = 0; prev_lvl[voice] = 0;
          end
          OP_OFF: begin
            if (ph[voice] != PH_IDLE) begin
              ph[voice] = PH_RELEASE; cnt[voice] = 0; rel_from[voice] = prev_lvl[voice];
            end
          end
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== test/tb.sv =====
// tb: stimulus and verdict for polyphonic_adsr_envelope_unit
// depends on adsr_pkg, the unit and adsr_env_checker
module tb;
  import adsr_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [1:0] opcode = OP_TICK;
  logic [VOICE_W-1:0] voice = '0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_ATTACK;
  logic [LEN_W-1:0] cfg_data = '0;
  logic busy, strobe, last;
  logic [VOICE_W-1:0] voice_out;
  logic [LVL_W-1:0] level;
  int errors, pending;
  int cycles = 0;

  always #4 clk = ~clk;

  polyphonic_adsr_envelope_unit uut (
    .clk, .rst, .start, .busy, .opcode, .voice, .strobe, .voice_out, .level, .last,
    .cfg_we, .cfg_index, .cfg_data
  );

  adsr_env_checker chk (
    .clk, .rst, .start, .busy, .opcode, .voice, .strobe, .voice_out, .level, .last,
    .cfg_we, .cfg_index, .cfg_data, .errors, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, logic [VOICE_W-1:0] v);
    start <= 1;
    opcode <= op;
    voice <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [LEN_W-1:0] d);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_envelope(logic [LEN_W-1:0] a, logic [LEN_W-1:0] d,
                              logic [LEN_W-1:0] r, logic [15:0] s);
    write_reg(REG_ATTACK, a);
    write_reg(REG_DECAY, d);
    write_reg(REG_RELEASE, r);
    write_reg(REG_SUSTAIN, {4'd0, s});
  endtask

  task automatic random_items(int n);
    int burst, sel;
    logic [1:0] op;
    while (n > 0) begin
      burst = $urandom_range(1, 10);
      while (burst > 0 && n > 0) begin
        sel = $urandom_range(0, 99);
        op = (sel < 50) ? OP_TICK : (sel < 75) ? OP_ON : (sel < 95) ? OP_OFF : OP_NONE;
        send_item(op, 4'($urandom));
        burst--;
        n--;
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 40));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset defaults, then short envelopes through every phase
    send_item(OP_TICK, 4'd0);
    send_item(OP_OFF, 4'd3);
    send_item(OP_NONE, 4'd15);
    send_item(OP_ON, 4'd0);
    send_item(OP_ON, 4'd15);
    send_item(OP_TICK, 4'd7);
    drain();
    set_envelope(20'd0, 20'd1, 20'd2, 16'd0);
    send_item(OP_ON, 4'd5);
    repeat (3) send_item(OP_TICK, 4'd0);
    send_item(OP_ON, 4'd5);
    send_item(OP_TICK, 4'd0);
    send_item(OP_OFF, 4'd5);
    repeat (4) send_item(OP_TICK, 4'd0);
    send_item(OP_OFF, 4'd0);
    for (int v = 0; v < 16; v++) send_item(OP_ON, 4'(v));
    send_item(OP_TICK, 4'd0);
    drain();
    set_envelope(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_item(OP_TICK, 4'd0);
    send_item(OP_OFF, 4'd9);
    send_item(OP_TICK, 4'd0);
    drain();

    set_envelope(20'd1, 20'd1, 20'd1, 16'hFFFF);
    random_items(60);
    drain();
    set_envelope(20'd3, 20'd5, 20'd7, 16'($urandom));
    random_items(70);
    drain();
    set_envelope(20'd0, 20'd0, 20'd0, 16'd0);
    random_items(50);
    drain();
    set_envelope(20'($urandom_range(1, 12)), 20'($urandom_range(1, 12)),
                 20'($urandom_range(1, 12)), 16'($urandom));
    random_items(70);
    drain();
    set_envelope(20'($urandom), 20'($urandom), 20'($urandom), 16'($urandom));
    random_items(40);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
